>>> sv/bpkd_pkg.sv
`default_nettype none
package bpkd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned BnW   = 5;
  localparam int unsigned NumKeys = 4;
  localparam int unsigned CfgIdxW = 2;

  // table index offsets, modulo 32 (subtracted offsets folded to additions)
  localparam logic [BnW-1:0] OfsW0A = 5'd0;
  localparam logic [BnW-1:0] OfsW0B = 5'd12;
  localparam logic [BnW-1:0] OfsW1A = 5'd3;
  localparam logic [BnW-1:0] OfsW1B = 5'd15;
  localparam logic [BnW-1:0] OfsW2A = 5'd6;
  localparam logic [BnW-1:0] OfsW2B = 5'd18;  // bn - 14
  localparam logic [BnW-1:0] OfsW3A = 5'd9;
  localparam logic [BnW-1:0] OfsW3B = 5'd21;  // bn - 11

  // key register indexes
  localparam logic [CfgIdxW-1:0] RegKey0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 2'd3;

  // rotation amount table
  function automatic logic [BnW-1:0] rot_amount(input logic [BnW-1:0] idx);
    logic [BnW-1:0] r;
    case (idx)
      5'd0:  r = 5'h01;
      5'd1:  r = 5'h02;
      5'd2:  r = 5'h03;
      5'd3:  r = 5'h04;
      5'd4:  r = 5'h05;
      5'd5:  r = 5'h06;
      5'd6:  r = 5'h07;
      5'd7:  r = 5'h09;
      5'd8:  r = 5'h0A;
      5'd9:  r = 5'h0B;
      5'd10: r = 5'h0C;
      5'd11: r = 5'h0D;
      5'd12: r = 5'h0E;
      5'd13: r = 5'h0F;
      5'd14: r = 5'h11;
      5'd15: r = 5'h12;
      5'd16: r = 5'h13;
      5'd17: r = 5'h14;
      5'd18: r = 5'h15;
      5'd19: r = 5'h16;
      5'd20: r = 5'h17;
      5'd21: r = 5'h19;
      5'd22: r = 5'h1A;
      5'd23: r = 5'h1B;
      5'd24: r = 5'h1C;
      5'd25: r = 5'h1D;
      5'd26: r = 5'h1E;
      5'd27: r = 5'h1F;
      5'd28: r = 5'h04;
      5'd29: r = 5'h0C;
      5'd30: r = 5'h14;
      default: r = 5'h1C;
    endcase
    return r;
  endfunction

  // rotate by 0..31 in either direction
  function automatic logic [WordW-1:0] rot(input logic [WordW-1:0] x,
                                           input logic [BnW-1:0] s,
                                           input logic left);
    logic [2*WordW-1:0] t;
    if (left) begin
      t = {x, x} << s;
      return t[2*WordW-1:WordW];
    end else begin
      t = {x, x} >> s;
      return t[WordW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/bpkd_lane.sv
`default_nettype none
module bpkd_lane (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire                          dir_left_i,
  input  wire  [bpkd_pkg::WordW-1:0]   key_i,
  input  wire  [bpkd_pkg::WordW-1:0]   word_i,
  input  wire  [bpkd_pkg::BnW-1:0]     amt_a_i,
  input  wire  [bpkd_pkg::BnW-1:0]     amt_b_i,
  output logic [bpkd_pkg::WordW-1:0]   word_o
);

  logic [bpkd_pkg::WordW-1:0] mix_d, mix_q;
  logic [bpkd_pkg::BnW-1:0]   amt_b_q;
  logic [bpkd_pkg::WordW-1:0] res_d, res_q;

  // rotated key folded into the data word
  assign mix_d = bpkd_pkg::rot(key_i, amt_a_i, dir_left_i) ^ word_i;
  // second rotation
  assign res_d = bpkd_pkg::rot(mix_q, amt_b_q, dir_left_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q   <= mix_d;
      amt_b_q <= amt_b_i;
      res_q   <= res_d;
    end
  end

  assign word_o = res_q;

endmodule
`default_nettype wire

>>> sv/block_position_keyed_descrambler.sv
// an input transfer passes through stage 1 and the lane's mix and result registers to the master side
// throughput: one 16-byte block per cycle; the only hold-off is a stalled
// output, which freezes all three stages together
// reset: rst_ni clears the stage valid bits and the four key words to zero
`default_nettype none
module block_position_keyed_descrambler (
  input  wire          clk_i,
  input  wire          rst_ni,
  // slave side
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: in_word_0, in_word_1, in_word_2, in_word_3, block_number, 3'b0 pad
  input  wire  [135:0] s_axis_tdata,
  input  wire          s_axis_tlast,   // last_block
  // master side
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata: out_word_0, out_word_1, out_word_2, out_word_3
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tlast,   // out_last
  // key register write port
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [31:0]  cfg_data_i
);

  localparam int unsigned W = bpkd_pkg::WordW;
  localparam int unsigned B = bpkd_pkg::BnW;

  // key registers
  logic [W-1:0] key_q [bpkd_pkg::NumKeys];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bpkd_pkg::NumKeys; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpkd_pkg::RegKey0: key_q[0] <= cfg_data_i;
        bpkd_pkg::RegKey1: key_q[1] <= cfg_data_i;
        bpkd_pkg::RegKey2: key_q[2] <= cfg_data_i;
        bpkd_pkg::RegKey3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output register is empty or being drained
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: byte-0 spread and table lookups
  logic [W-1:0] in_w [4];
  logic [B-1:0] bn;
  logic [7:0]   b0;
  logic [W-1:0] spread;

  assign in_w[0] = s_axis_tdata[31:0];
  assign in_w[1] = s_axis_tdata[63:32];
  assign in_w[2] = s_axis_tdata[95:64];
  assign in_w[3] = s_axis_tdata[127:96];
  assign bn      = s_axis_tdata[132:128];
  assign b0      = in_w[0][7:0];
  assign spread  = {b0, b0, b0, b0};

  logic [W-1:0] s1_w_d [4];
  logic [B-1:0] s1_a_d [4];
  logic [B-1:0] s1_b_d [4];

  always_comb begin
    s1_w_d[0] = in_w[0] ^ {spread[W-1:8], 8'h00};   // byte 0 stays as is
    s1_w_d[1] = in_w[1] ^ spread;
    s1_w_d[2] = in_w[2] ^ spread;
    s1_w_d[3] = in_w[3] ^ spread;
    s1_a_d[0] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW0A);
    s1_b_d[0] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW0B);
    s1_a_d[1] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW1A);
    s1_b_d[1] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW1B);
    s1_a_d[2] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW2A);
    s1_b_d[2] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW2B);
    s1_a_d[3] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW3A);
    s1_b_d[3] = bpkd_pkg::rot_amount(bn + bpkd_pkg::OfsW3B);
  end

  logic [W-1:0] s1_w_q [4];
  logic [B-1:0] s1_a_q [4];
  logic [B-1:0] s1_b_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_w_q <= s1_w_d;
      s1_a_q <= s1_a_d;
      s1_b_q <= s1_b_d;
    end
  end

  // valid and last travel alongside the data
  logic [2:0] vld_d, vld_q;
  logic [2:0] last_d, last_q;

  assign vld_d  = {vld_q[1:0], s_axis_tvalid};
  assign last_d = {last_q[1:0], s_axis_tlast};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) last_q <= last_d;
  end

  // stages 2 and 3: one lane per word; words 1 and 3 rotate left
  logic [W-1:0] out_w [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    bpkd_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (en),
      .dir_left_i (1'(g % 2)),
      .key_i      (key_q[g]),
      .word_i     (s1_w_q[g]),
      .amt_a_i    (s1_a_q[g]),
      .amt_b_i    (s1_b_q[g]),
      .word_o     (out_w[g])
    );
  end

  assign m_axis_tvalid = vld_q[2];
  assign m_axis_tlast  = last_q[2];
  assign m_axis_tdata  = {out_w[3], out_w[2], out_w[1], out_w[0]};

endmodule
`default_nettype wire
